FILE: rtl/gda_pkg.sv
// ----------------------------------------------------------------------------
// gda_pkg
// Shared types, constants and calendar helpers for the date adder.
// ----------------------------------------------------------------------------
package gda_pkg;

    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int YEAR_W   = 14;
    localparam int OFFSET_W = 17;

    // working widths: day sum spans -65536..65566, year drifts by about 180
    localparam int WDAY_W  = 18;
    localparam int WYEAR_W = 16;
    localparam int Y400_W  = 9;
    localparam int STEP_W  = 3;

    localparam logic [STEP_W-1:0] REDUCE_FIRST = 3'd5;
    localparam logic [STEP_W-1:0] REDUCE_LAST  = 3'd0;

    localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
    localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
    localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;

    localparam logic [Y400_W-1:0] Y400_MAX = 9'd399;
    localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
    localparam logic [DAY_W-1:0]  DAY_MAX  = 5'd31;
    localparam logic [DAY_W-1:0]  DAY_MIN  = 5'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_WALK,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic              load;
        logic              reduce;
        logic              reduce_last;
        logic [STEP_W-1:0] step_idx;
        logic              walk;
        logic              store_out;
    } cmd_t;

    typedef struct packed {
        logic walk_done;
    } status_t;

    // 400 << k, subtracted by the restoring reduction of the start year
    function automatic logic [YEAR_W-1:0] reduce_step(input logic [STEP_W-1:0] k);
        logic [YEAR_W-1:0] r;
        case (k)
            3'd5:    r = 14'd12800;
            3'd4:    r = 14'd6400;
            3'd3:    r = 14'd3200;
            3'd2:    r = 14'd1600;
            3'd1:    r = 14'd800;
            default: r = 14'd400;
        endcase
        return r;
    endfunction

    // leap test from the year modulo 400
    function automatic logic is_leap(input logic [Y400_W-1:0] y400);
        logic century;
        century = (y400 == 9'd100) || (y400 == 9'd200) || (y400 == 9'd300);
        return (y400 == '0) || (!century && (y400[1:0] == 2'b00));
    endfunction

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] month,
                                                     input logic leap);
        logic [DAY_W-1:0] n;
        case (month)
            FEBRUARY: n = leap ? 5'd29 : 5'd28;
            4'd4:     n = 5'd30;
            4'd6:     n = 5'd30;
            4'd9:     n = 5'd30;
            4'd11:    n = 5'd30;
            default:  n = 5'd31;
        endcase
        return n;
    endfunction

endpackage

FILE: rtl/gda_ctrl.sv
// ----------------------------------------------------------------------------
// gda_ctrl
// Sequencer for the date adder: load, year reduction, month walk, hand-off.
// ----------------------------------------------------------------------------
module gda_ctrl
    import gda_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= REDUCE_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && out_stall;
        cmd             = '0;
        cmd.step_idx    = cnt_reg;
        in_stall        = (state_reg != ST_IDLE);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = REDUCE_FIRST;
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                cmd.reduce = 1'b1;
                if (cnt_reg == REDUCE_LAST)
                begin
                    cmd.reduce_last = 1'b1;
                    state_next      = ST_WALK;
                end
                else
                begin
                    cnt_next = cnt_reg - 3'd1;
                end
            end
            ST_WALK:
            begin
                cmd.walk = 1'b1;
                if (status.walk_done)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.store_out  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    a_accept_starts_reduce: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_REDUCE && cnt_reg == REDUCE_FIRST))
        else $error("accepted transaction did not start the year reduction");

    a_store_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store_out |=> out_valid_reg)
        else $error("stored result not presented");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store_out |-> (!out_valid_reg || !out_stall))
        else $error("pending result overwritten");

endmodule

FILE: rtl/gda_datapath.sv
// ----------------------------------------------------------------------------
// gda_datapath
// Day, month and year registers with the month-step unit and output register.
// ----------------------------------------------------------------------------
module gda_datapath
    import gda_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  cmd_t                        cmd,
    output status_t                     status,
    input  logic [MONTH_W-1:0]          start_month,
    input  logic [DAY_W-1:0]            start_day,
    input  logic [YEAR_W-1:0]           start_year,
    input  logic signed [OFFSET_W-1:0]  day_offset,
    output logic [MONTH_W-1:0]          result_month,
    output logic [DAY_W-1:0]            result_day,
    output logic [YEAR_W-1:0]           result_year,
    output logic                        out_of_range
);

    logic signed [WDAY_W-1:0]  day_reg, day_next;
    logic [MONTH_W-1:0]        month_reg, month_next;
    logic signed [WYEAR_W-1:0] year_reg, year_next;
    logic [Y400_W-1:0]         y400_reg, y400_next;
    logic [YEAR_W-1:0]         rem_reg, rem_next;

    logic [MONTH_W-1:0] res_month_reg;
    logic [DAY_W-1:0]   res_day_reg;
    logic [YEAR_W-1:0]  res_year_reg;
    logic               res_flag_reg;

    logic [DAY_W-1:0]          len_cur, len_prev;
    logic                      step_fwd, step_bwd;
    logic [MONTH_W-1:0]        month_prev;
    logic signed [WYEAR_W-1:0] year_prev;
    logic [Y400_W-1:0]         y400_prev;
    logic [YEAR_W-1:0]         step_sub;
    logic [YEAR_W-1:0]         rem_red;

    always_comb
    begin
        len_cur  = month_days(month_reg, is_leap(y400_reg));
        step_fwd = day_reg > $signed({{(WDAY_W-DAY_W){1'b0}}, len_cur});
        step_bwd = day_reg < $signed(18'sd1);

        // previous month, for the backward step
        if (month_reg == JANUARY)
        begin
            month_prev = DECEMBER;
            year_prev  = year_reg - 16'sd1;
            y400_prev  = (y400_reg == '0) ? Y400_MAX : y400_reg - 9'd1;
        end
        else
        begin
            month_prev = month_reg - 4'd1;
            year_prev  = year_reg;
            y400_prev  = y400_reg;
        end
        len_prev = month_days(month_prev, is_leap(y400_prev));

        step_sub = reduce_step(cmd.step_idx);
        rem_red  = (rem_reg >= step_sub) ? rem_reg - step_sub : rem_reg;
    end

    assign status.walk_done = !step_fwd && !step_bwd;

    always_comb
    begin
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        y400_next  = y400_reg;
        rem_next   = rem_reg;

        if (cmd.load)
        begin
            if (start_month == '0)
                month_next = JANUARY;
            else if (start_month > DECEMBER)
                month_next = DECEMBER;
            else
                month_next = start_month;
            day_next  = $signed({{(WDAY_W-DAY_W){1'b0}}, start_day})
                      + {{(WDAY_W-OFFSET_W){day_offset[OFFSET_W-1]}}, day_offset};
            year_next = $signed({{(WYEAR_W-YEAR_W){1'b0}}, start_year});
            rem_next  = start_year;
        end
        else if (cmd.reduce)
        begin
            rem_next = rem_red;
            if (cmd.reduce_last)
                y400_next = rem_red[Y400_W-1:0];
        end
        else if (cmd.walk)
        begin
            if (step_fwd)
            begin
                day_next = day_reg - $signed({{(WDAY_W-DAY_W){1'b0}}, len_cur});
                if (month_reg == DECEMBER)
                begin
                    month_next = JANUARY;
                    year_next  = year_reg + 16'sd1;
                    y400_next  = (y400_reg == Y400_MAX) ? '0 : y400_reg + 9'd1;
                end
                else
                begin
                    month_next = month_reg + 4'd1;
                end
            end
            else if (step_bwd)
            begin
                month_next = month_prev;
                year_next  = year_prev;
                y400_next  = y400_prev;
                day_next   = day_reg + $signed({{(WDAY_W-DAY_W){1'b0}}, len_prev});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        day_reg   <= day_next;
        month_reg <= month_next;
        year_reg  <= year_next;
        y400_reg  <= y400_next;
        rem_reg   <= rem_next;
        if (cmd.store_out)
        begin
            if (year_reg < 16'sd0)
            begin
                res_month_reg <= JANUARY;
                res_day_reg   <= DAY_MIN;
                res_year_reg  <= '0;
                res_flag_reg  <= 1'b1;
            end
            else if (year_reg > $signed({{(WYEAR_W-YEAR_W){1'b0}}, YEAR_MAX}))
            begin
                res_month_reg <= DECEMBER;
                res_day_reg   <= DAY_MAX;
                res_year_reg  <= YEAR_MAX;
                res_flag_reg  <= 1'b1;
            end
            else
            begin
                res_month_reg <= month_reg;
                res_day_reg   <= day_reg[DAY_W-1:0];
                res_year_reg  <= year_reg[YEAR_W-1:0];
                res_flag_reg  <= 1'b0;
            end
        end
    end

    assign result_month = res_month_reg;
    assign result_day   = res_day_reg;
    assign result_year  = res_year_reg;
    assign out_of_range = res_flag_reg;

    a_month_legal: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk |-> (month_reg >= JANUARY && month_reg <= DECEMBER))
        else $error("month left 1..12 during walk");

    a_y400_tracks_year: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.walk |-> (y400_reg <= Y400_MAX && y400_reg[1:0] == year_reg[1:0]))
        else $error("year modulo 400 out of step with year");

    a_done_day_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.walk && status.walk_done) |-> (day_reg >= 18'sd1 && day_reg <= 18'sd31))
        else $error("walk ended with day outside the month");

endmodule

FILE: rtl/gregorian_date_add_days.sv
// ----------------------------------------------------------------------------
// gregorian_date_add_days
// Adds a signed day offset to a Gregorian date, walking one month per cycle.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  input    in_valid / in_stall  start_month, start_day, start_year, day_offset
//  output   out_valid/out_stall  result_month, result_day, result_year,
//                                out_of_range
//
//  Each transaction is loaded, its start year is reduced modulo 400 in six
//  restoring steps, the month-step loop crosses M month boundaries (up to
//  about 2150) and stops, and the result is written to the output register.
//  in_stall is high from acceptance until the result is written.
//  A waiting result holds the last step; the next input is taken meanwhile.
//  rst_n clears the sequencer and out_valid asynchronously.
// ----------------------------------------------------------------------------
module gregorian_date_add_days
    import gda_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [MONTH_W-1:0]          start_month,
    input  logic [DAY_W-1:0]            start_day,
    input  logic [YEAR_W-1:0]           start_year,
    input  logic signed [OFFSET_W-1:0]  day_offset,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [MONTH_W-1:0]          result_month,
    output logic [DAY_W-1:0]            result_day,
    output logic [YEAR_W-1:0]           result_year,
    output logic                        out_of_range
);

    cmd_t    cmd;
    status_t status;

    gda_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    gda_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .start_month  (start_month),
        .start_day    (start_day),
        .start_year   (start_year),
        .day_offset   (day_offset),
        .result_month (result_month),
        .result_day   (result_day),
        .result_year  (result_year),
        .out_of_range (out_of_range)
    );

endmodule

FILE: sim/gregorian_date_add_days_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gregorian_date_add_days_tb
// Drives dates and signed day offsets into the date adder and checks each
// returned date against a date walk computed here, including the
// out-of-range clamp, under random idling on both channels.
// ----------------------------------------------------------------------------
module gregorian_date_add_days_tb;

    import gda_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 9;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 12;
    localparam int RUN_LIMIT_NS = 30_000_000;
    localparam int YEAR_TOP     = 9999;

    typedef struct packed {
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [YEAR_W-1:0]  year;
        logic               oor;
    } cal_date_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [MONTH_W-1:0]         start_month = '0;
    logic [DAY_W-1:0]           start_day = '0;
    logic [YEAR_W-1:0]          start_year = '0;
    logic signed [OFFSET_W-1:0] day_offset = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [MONTH_W-1:0]         result_month;
    logic [DAY_W-1:0]           result_day;
    logic [YEAR_W-1:0]          result_year;
    logic                       out_of_range;

    cal_date_t expected_dates [$];
    int        errors = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    logic      hold_request = 1'b0;
    int        hold_left = 0;

    gregorian_date_add_days u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .start_month  (start_month),
        .start_day    (start_day),
        .start_year   (start_year),
        .day_offset   (day_offset),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_month (result_month),
        .result_day   (result_day),
        .result_year  (result_year),
        .out_of_range (out_of_range)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    function automatic int month_length(input int month, input int year);
        int n;
        case (month)
            2:       n = 28;
            4:       n = 30;
            6:       n = 30;
            9:       n = 30;
            11:      n = 30;
            default: n = 31;
        endcase
        if (month == 2 && ((year % 400 == 0) || (year % 100 != 0 && year % 4 == 0)))
            n = n + 1;
        return n;
    endfunction

    // Walk month by month from the start date, then clamp the year.
    function automatic cal_date_t add_days(input logic [MONTH_W-1:0] m_in,
                                           input logic [DAY_W-1:0] d_in,
                                           input logic [YEAR_W-1:0] y_in,
                                           input logic signed [OFFSET_W-1:0] off);
        int        month;
        int        day;
        int        year;
        cal_date_t r;
        month = int'(m_in);
        if (month < 1)
            month = 1;
        if (month > 12)
            month = 12;
        day  = int'(d_in) + int'(off);
        year = int'(y_in);
        while (day > month_length(month, year))
        begin
            day   = day - month_length(month, year);
            month = month + 1;
            if (month > 12)
            begin
                month = 1;
                year  = year + 1;
            end
        end
        while (day < 1)
        begin
            month = month - 1;
            if (month < 1)
            begin
                month = 12;
                year  = year - 1;
            end
            day = day + month_length(month, year);
        end
        r.oor = 1'b0;
        if (year < 0)
        begin
            r.oor = 1'b1;
            year  = 0;
            month = 1;
            day   = 1;
        end
        else if (year > YEAR_TOP)
        begin
            r.oor = 1'b1;
            year  = YEAR_TOP;
            month = 12;
            day   = 31;
        end
        r.month = month[MONTH_W-1:0];
        r.day   = day[DAY_W-1:0];
        r.year  = year[YEAR_W-1:0];
        return r;
    endfunction

    // Long receiver hold-off, counted here so the block fills and stalls its input.
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_request)
            hold_left <= HOLD_CYCLES;
    end

    always @(posedge clk)
    begin
        out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin : check_result
        cal_date_t want;
        cal_date_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{result_month, result_day, result_year, out_of_range};
            if (expected_dates.size() == 0)
            begin
                $display("%0t: unexpected result %0d/%0d/%0d oor=%0b", $time,
                         got.month, got.day, got.year, got.oor);
                errors = errors + 1;
            end
            else
            begin
                want = expected_dates.pop_front();
                if (got !== want)
                begin
                    $display("%0t: date mismatch expected %0d/%0d/%0d oor=%0b, got %0d/%0d/%0d oor=%0b",
                             $time, want.month, want.day, want.year, want.oor,
                             got.month, got.day, got.year, got.oor);
                    errors = errors + 1;
                end
            end
        end
    end

    // Called at a rising edge; returns at the edge where the transaction is taken.
    task automatic send_date(input logic [MONTH_W-1:0] m, input logic [DAY_W-1:0] d,
                             input logic [YEAR_W-1:0] y,
                             input logic signed [OFFSET_W-1:0] off);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid    <= 1'b1;
        start_month <= m;
        start_day   <= d;
        start_year  <= y;
        day_offset  <= off;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_dates.push_back(add_days(m, d, y, off));
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (expected_dates.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic test_range_edges;
        send_date(4'd1, 5'd1, 14'd0, OFFSET_W'(0));
        send_date(4'd12, 5'd31, 14'd9999, OFFSET_W'(0));
        send_date(4'd1, 5'd1, 14'd0, OFFSET_W'(-1));
        send_date(4'd12, 5'd31, 14'd9999, OFFSET_W'(1));
        send_date(4'd1, 5'd1, 14'd2000, OFFSET_W'(65535));
        send_date(4'd12, 5'd31, 14'd9999, OFFSET_W'(-65536));
        send_date(4'd1, 5'd1, 14'd0, OFFSET_W'(-65536));
        send_date(4'd12, 5'd31, 14'd9999, OFFSET_W'(65535));
        send_date(4'd6, 5'd15, 14'd5000, OFFSET_W'(-1));
    endtask

    task automatic test_leap_years;
        send_date(4'd2, 5'd28, 14'd2000, OFFSET_W'(1));
        send_date(4'd2, 5'd28, 14'd1900, OFFSET_W'(1));
        send_date(4'd2, 5'd28, 14'd2004, OFFSET_W'(1));
        send_date(4'd2, 5'd28, 14'd2001, OFFSET_W'(1));
        send_date(4'd3, 5'd1, 14'd2000, OFFSET_W'(-1));
        send_date(4'd3, 5'd1, 14'd2100, OFFSET_W'(-1));
    endtask

    // Month zero, months past December, day zero, day past month end, year past 9999.
    task automatic test_odd_fields;
        send_date(4'd0, 5'd15, 14'd2010, OFFSET_W'(0));
        send_date(4'd13, 5'd1, 14'd2010, OFFSET_W'(0));
        send_date(4'd15, 5'd31, 14'd2010, OFFSET_W'(31));
        send_date(4'd3, 5'd0, 14'd2024, OFFSET_W'(0));
        send_date(4'd2, 5'd31, 14'd2023, OFFSET_W'(0));
        send_date(4'd1, 5'd0, 14'd0, OFFSET_W'(0));
        send_date(4'd6, 5'd10, 14'd10000, OFFSET_W'(0));
        send_date(4'd6, 5'd10, 14'd10100, OFFSET_W'(-65536));
        send_date(4'd15, 5'd31, 14'd16383, OFFSET_W'(65535));
        send_date(4'd0, 5'd0, 14'd16383, OFFSET_W'(-65536));
    endtask

    task automatic test_random(input int count, input int send_pct, input int recv_pct);
        logic [MONTH_W-1:0]         m;
        logic [DAY_W-1:0]           d;
        logic [YEAR_W-1:0]          y;
        logic signed [OFFSET_W-1:0] off;
        int                         pick;
        send_idle_pct  <= send_pct;
        recv_stall_pct <= recv_pct;
        repeat (count)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                y = YEAR_W'($urandom_range(0, 16383));
            else if (pick < 20)
                y = YEAR_W'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                 : $urandom_range(9996, 9999));
            else
                y = YEAR_W'($urandom_range(0, YEAR_TOP));
            if ($urandom_range(99) < 12)
            begin
                m = MONTH_W'($urandom_range(0, 15));
                d = DAY_W'($urandom_range(0, 31));
            end
            else
            begin
                m = MONTH_W'($urandom_range(1, 12));
                d = DAY_W'($urandom_range(1, month_length(int'(m), int'(y))));
            end
            // keep most walks short; a few span the whole offset range
            if ($urandom_range(99) < 15)
                off = OFFSET_W'(int'($urandom_range(0, 131071)) - 65536);
            else
                off = OFFSET_W'(int'($urandom_range(0, 4000)) - 2000);
            send_date(m, d, y, off);
        end
        drain();
    endtask

    task automatic test_backpressure;
        send_idle_pct  <= 0;
        recv_stall_pct <= 0;
        hold_request   <= 1'b1;
        @(posedge clk);
        hold_request   <= 1'b0;
        repeat (8)
            send_date(MONTH_W'($urandom_range(1, 12)), DAY_W'($urandom_range(1, 28)),
                      YEAR_W'($urandom_range(0, YEAR_TOP)),
                      OFFSET_W'(int'($urandom_range(0, 200)) - 100));
        drain();
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_idle_pct  <= 20;
        recv_stall_pct <= 63;
        test_range_edges();
        test_leap_years();
        test_odd_fields();
        drain();
        test_random(80, 20, 63);
        test_random(80, 63, 20);
        test_random(80, 0, 0);
        test_backpressure();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("%0t: run limit reached", $time);
        $display("*** FAILED ***");
        $finish;
    end

endmodule
